>>> src/bdef_pkg.sv
// Shared types and constants for the bencode dictionary end finder.
`timescale 1ns / 1ps

package bdef_pkg;

	localparam int OFF_W = 16;
	localparam int STATUS_W = 3;
	localparam int MODE_W = 3;

	// Scan modes
	localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DIGITS  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STRING  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INTEGER = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DONE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BAD     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DEPTH   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_LONG    = 3'd7;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_TRAIL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DEPTH    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LONG     = 3'd4;

	// Bencode token characters
	localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
	localparam logic [7:0] CH_LIST  = 8'h6C; // 'l'
	localparam logic [7:0] CH_END   = 8'h65; // 'e'
	localparam logic [7:0] CH_INT   = 8'h69; // 'i'
	localparam logic [7:0] CH_COLON = 8'h3A; // ':'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    end_offset;
		logic [OFF_W-1:0]    trailing_length;
	} out_t;

endpackage

>>> src/bdef_in_reg.sv
// Input register stage for the bencode dictionary end finder.
`timescale 1ns / 1ps

module bdef_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bdef_pkg::in_t  in_data,
	input  logic           advance,
	output logic           valid_s1,
	output bdef_pkg::in_t  data_s1
);

	logic          vld_s1;
	bdef_pkg::in_t dat_s1;

	// Take a new byte whenever the stage is empty or moves on this cycle
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dat_s1 <= in_data;
		end
	end

	assign valid_s1 = vld_s1;
	assign data_s1  = dat_s1;

endmodule

>>> src/bdef_scan.sv
// Scan state update and result register for the bencode dictionary end finder.
`timescale 1ns / 1ps

module bdef_scan #(
	parameter int MAX_MESSAGE_BYTES = 32768,
	parameter int MAX_NEST_DEPTH    = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  bdef_pkg::in_t  data_s1,
	output logic           advance,
	output logic           out_valid,
	input  logic           out_ready,
	output bdef_pkg::out_t out_data
);

	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES * 10 + 10);
	localparam int DEP_W = $clog2(MAX_NEST_DEPTH + 1);

	logic [bdef_pkg::MODE_W-1:0] mode_q, mode_n;
	logic [DEP_W-1:0]            depth_q, depth_n;
	logic [POS_W-1:0]            acc_q, acc_n;
	logic [POS_W-1:0]            pos_q, pos_n;
	logic [POS_W-1:0]            found_q, found_n;
	logic                        out_valid_q;
	bdef_pkg::out_t              out_data_q;
	bdef_pkg::out_t              result;
	logic [7:0]                  b;
	logic                        is_digit;
	logic [LEN_W-1:0]            acc_prod;
	logic [POS_W-1:0]            acc_dec;
	logic [POS_W-1:0]            trail;
	logic                        take;

	assign b        = data_s1.data_byte;
	assign is_digit = b inside {[bdef_pkg::CH_ZERO:bdef_pkg::CH_NINE]};
	assign acc_prod = (LEN_W'(acc_q) << 3) + (LEN_W'(acc_q) << 1) + LEN_W'(b[3:0]);
	assign acc_dec  = (acc_q != '0) ? acc_q - POS_W'(1) : acc_q;

	// Hold a final byte while the result register is still occupied
	assign advance = !valid_s1 || !data_s1.last_byte || !out_valid_q || out_ready;
	assign take    = valid_s1 && advance;

	always_comb begin
		mode_n  = mode_q;
		depth_n = depth_q;
		acc_n   = acc_q;
		pos_n   = pos_q;
		found_n = found_q;
		if (pos_q >= POS_W'(MAX_MESSAGE_BYTES)) begin
			mode_n = bdef_pkg::MODE_LONG;
		end else begin
			pos_n = pos_q + POS_W'(1);
			case (mode_q)
				bdef_pkg::MODE_NORMAL: begin
					if (b == bdef_pkg::CH_DICT || b == bdef_pkg::CH_LIST) begin
						if (depth_q >= DEP_W'(MAX_NEST_DEPTH)) begin
							mode_n = bdef_pkg::MODE_DEPTH;
						end else begin
							depth_n = depth_q + DEP_W'(1);
						end
					end else if (b == bdef_pkg::CH_END) begin
						if (depth_q == '0) begin
							mode_n = bdef_pkg::MODE_BAD;
						end else begin
							depth_n = depth_q - DEP_W'(1);
							if (depth_q == DEP_W'(1)) begin
								found_n = pos_q + POS_W'(1);
								mode_n  = bdef_pkg::MODE_DONE;
							end
						end
					end else if (is_digit) begin
						acc_n  = POS_W'(b[3:0]);
						mode_n = bdef_pkg::MODE_DIGITS;
					end else if (b == bdef_pkg::CH_INT) begin
						mode_n = bdef_pkg::MODE_INTEGER;
					end
				end
				bdef_pkg::MODE_DIGITS: begin
					if (is_digit) begin
						acc_n = POS_W'(acc_prod);
						if (acc_prod > LEN_W'(MAX_MESSAGE_BYTES)) begin
							mode_n = bdef_pkg::MODE_LONG;
						end
					end else if (b == bdef_pkg::CH_COLON) begin
						mode_n = (acc_q == '0) ? bdef_pkg::MODE_NORMAL : bdef_pkg::MODE_STRING;
					end else begin
						mode_n = bdef_pkg::MODE_BAD;
					end
				end
				bdef_pkg::MODE_STRING: begin
					acc_n = acc_dec;
					if (acc_dec == '0) begin
						mode_n = bdef_pkg::MODE_NORMAL;
					end
				end
				bdef_pkg::MODE_INTEGER: begin
					if (b == bdef_pkg::CH_END) begin
						mode_n = bdef_pkg::MODE_NORMAL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign trail = pos_n - found_n;

	always_comb begin
		result.status          = bdef_pkg::ST_BAD;
		result.end_offset      = '0;
		result.trailing_length = '0;
		case (mode_n)
			bdef_pkg::MODE_LONG:  result.status = bdef_pkg::ST_LONG;
			bdef_pkg::MODE_DEPTH: result.status = bdef_pkg::ST_DEPTH;
			bdef_pkg::MODE_DONE: begin
				result.end_offset      = bdef_pkg::OFF_W'(found_n);
				result.trailing_length = bdef_pkg::OFF_W'(trail);
				result.status = (trail == '0) ? bdef_pkg::ST_NO_TRAIL : bdef_pkg::ST_FOUND;
			end
			default: result.status = bdef_pkg::ST_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bdef_pkg::MODE_NORMAL;
			depth_q <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
			found_q <= '0;
		end else if (take) begin
			if (data_s1.last_byte) begin
				// Drop all message state once the result is latched
				mode_q  <= bdef_pkg::MODE_NORMAL;
				depth_q <= '0;
				acc_q   <= '0;
				pos_q   <= '0;
				found_q <= '0;
			end else begin
				mode_q  <= mode_n;
				depth_q <= depth_n;
				acc_q   <= acc_n;
				pos_q   <= pos_n;
				found_q <= found_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && data_s1.last_byte) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && data_s1.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEP_W'(MAX_NEST_DEPTH))
		else $error("nesting depth above limit");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_MESSAGE_BYTES))
		else $error("byte position above limit");

	a_done_closed: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == bdef_pkg::MODE_DONE |-> depth_q == '0 && found_q != '0)
		else $error("end found with open containers");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && data_s1.last_byte |=> pos_q == '0 && mode_q == bdef_pkg::MODE_NORMAL
			&& out_valid_q)
		else $error("final byte did not reset scan state");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.status <= bdef_pkg::ST_LONG)
		else $error("status code out of range");

endmodule

>>> src/bencode_dict_end_finder_top.sv
// A final byte is held in the input register, then the scan stage registers its result in the result register.
// Throughput: one byte per cycle while no final byte is stalled; the scan state updates in a register loop.
// Only a byte marked last produces a result transaction.
// A final byte stalls only while the previous result has not been taken.
// Reset (arst_n low, asynchronous) clears both stages and returns the scan to depth 0, position 0.
`timescale 1ns / 1ps

module bencode_dict_end_finder_top #(
	parameter int MAX_MESSAGE_BYTES = 32768,
	parameter int MAX_NEST_DEPTH    = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bdef_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bdef_pkg::out_t out_data
);

	logic          advance;
	logic          valid_s1;
	bdef_pkg::in_t data_s1;

	bdef_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	bdef_scan #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
		.MAX_NEST_DEPTH    (MAX_NEST_DEPTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> verif/tb_bencode_dict_end_finder_top.sv
// Testbench for the bencode dictionary end finder: directed and random messages checked by a predictor.
`timescale 1ns / 1ps

module tb_bencode_dict_end_finder_top;

	localparam int MSG_LIMIT   = 32768;
	localparam int DEPTH_LIMIT = 15;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BYTES = 720;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bdef_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bdef_pkg::out_t out_data;

	bencode_dict_end_finder_top #(
		.MAX_MESSAGE_BYTES(MSG_LIMIT),
		.MAX_NEST_DEPTH(DEPTH_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Predictor state for the message in flight
	logic [bdef_pkg::MODE_W-1:0] scan_st = bdef_pkg::MODE_NORMAL;
	int unsigned nest_lvl = 0;
	int unsigned str_len = 0;
	int unsigned byte_pos = 0;
	int unsigned close_pos = 0;

	bdef_pkg::out_t expected_verdicts[$];
	bdef_pkg::out_t want;
	logic [7:0] msg_buf[$];
	int fail_count = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int stall_style = 0;
	int stall_left = 0;

	task automatic track_byte(input bdef_pkg::in_t item);
		logic [7:0] b;
		bdef_pkg::out_t verdict;
		b = item.data_byte;
		if (byte_pos >= MSG_LIMIT) begin
			scan_st = bdef_pkg::MODE_LONG;
		end else begin
			case (scan_st)
				bdef_pkg::MODE_NORMAL: begin
					if (b == bdef_pkg::CH_DICT || b == bdef_pkg::CH_LIST) begin
						if (nest_lvl >= DEPTH_LIMIT)
							scan_st = bdef_pkg::MODE_DEPTH;
						else
							nest_lvl++;
					end else if (b == bdef_pkg::CH_END) begin
						if (nest_lvl == 0) begin
							scan_st = bdef_pkg::MODE_BAD;
						end else begin
							nest_lvl--;
							if (nest_lvl == 0) begin
								close_pos = byte_pos + 1;
								scan_st = bdef_pkg::MODE_DONE;
							end
						end
					end else if (b >= bdef_pkg::CH_ZERO && b <= bdef_pkg::CH_NINE) begin
						str_len = b - bdef_pkg::CH_ZERO;
						scan_st = bdef_pkg::MODE_DIGITS;
					end else if (b == bdef_pkg::CH_INT) begin
						scan_st = bdef_pkg::MODE_INTEGER;
					end
				end
				bdef_pkg::MODE_DIGITS: begin
					if (b >= bdef_pkg::CH_ZERO && b <= bdef_pkg::CH_NINE) begin
						str_len = str_len * 10 + (b - bdef_pkg::CH_ZERO);
						if (str_len > MSG_LIMIT)
							scan_st = bdef_pkg::MODE_LONG;
					end else if (b == bdef_pkg::CH_COLON) begin
						scan_st = (str_len == 0) ? bdef_pkg::MODE_NORMAL : bdef_pkg::MODE_STRING;
					end else begin
						scan_st = bdef_pkg::MODE_BAD;
					end
				end
				bdef_pkg::MODE_STRING: begin
					if (str_len > 0)
						str_len--;
					if (str_len == 0)
						scan_st = bdef_pkg::MODE_NORMAL;
				end
				bdef_pkg::MODE_INTEGER: begin
					if (b == bdef_pkg::CH_END)
						scan_st = bdef_pkg::MODE_NORMAL;
				end
				default: ;
			endcase
			byte_pos++;
		end
		if (item.last_byte) begin
			verdict = '0;
			case (scan_st)
				bdef_pkg::MODE_LONG: verdict.status = bdef_pkg::ST_LONG;
				bdef_pkg::MODE_DEPTH: verdict.status = bdef_pkg::ST_DEPTH;
				bdef_pkg::MODE_DONE: begin
					verdict.end_offset = 16'(close_pos);
					verdict.trailing_length = 16'(byte_pos - close_pos);
					verdict.status = (byte_pos == close_pos) ? bdef_pkg::ST_NO_TRAIL
						: bdef_pkg::ST_FOUND;
				end
				default: verdict.status = bdef_pkg::ST_BAD;
			endcase
			expected_verdicts.push_back(verdict);
			scan_st = bdef_pkg::MODE_NORMAL;
			nest_lvl = 0;
			str_len = 0;
			byte_pos = 0;
			close_pos = 0;
		end
	endtask

	// Sample between edges: nothing is driven on the falling edge, so these values
	// are the ones the next rising edge sees. Check results before predicting.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result with none pending: status %0d end %0d trail %0d",
							out_data.status, out_data.end_offset, out_data.trailing_length);
				end else begin
					want = expected_verdicts.pop_front();
					if (out_data.status !== want.status ||
						out_data.end_offset !== want.end_offset ||
						out_data.trailing_length !== want.trailing_length) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: status %0d/%0d end %0d/%0d trail %0d/%0d (exp/act)",
								want.status, out_data.status, want.end_offset,
								out_data.end_offset, want.trailing_length,
								out_data.trailing_length);
					end
				end
			end
			if (in_valid && in_ready)
				track_byte(in_data);
		end
	end

	// Receiver: switch between always ready, random stalls and a sparse periodic pattern
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (cycle_count % 5 == 0);
		endcase
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Hold valid and payload until the transaction completes; gaps come between bursts.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		logic taken;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: lst};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		burst_left--;
	endtask

	task automatic send_buffer();
		foreach (msg_buf[i])
			send_byte(msg_buf[i], i == msg_buf.size() - 1);
	endtask

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_buf.push_back(s[i]);
	endfunction

	task automatic send_text(input string s);
		msg_buf.delete();
		append_text(s);
		send_buffer();
	endtask

	function automatic void push_decimal(input int unsigned n);
		logic [7:0] digits[$];
		do begin
			digits.push_front(bdef_pkg::CH_ZERO + 8'(n % 10));
			n = n / 10;
		end while (n != 0);
		foreach (digits[i])
			msg_buf.push_back(digits[i]);
	endfunction

	task automatic test_wellformed();
		send_text("de");
		send_text("le");
		send_text("d3:abce");
		send_text("d3:abcexyz");
		send_text("d1:ki-42ee");
		send_text("d3:edle");
		send_text("d1:xli1ei2eeeeee");
		send_text("5:hellod0:ee");
		send_text("0:dex");
	endtask

	task automatic test_malformed();
		send_text("e");
		send_text("ede");
		send_text("d12xe");
		send_text("d5:ab");
		send_text("di12");
		send_text("d12");
		send_text("dd");
		send_text("x");
		send_text("i5e");
	endtask

	task automatic test_nest_limit();
		msg_buf.delete();
		for (int i = 0; i < DEPTH_LIMIT; i++)
			msg_buf.push_back(i[0] ? bdef_pkg::CH_LIST : bdef_pkg::CH_DICT);
		repeat (DEPTH_LIMIT) msg_buf.push_back(bdef_pkg::CH_END);
		send_buffer();
		msg_buf.delete();
		repeat (DEPTH_LIMIT + 1) msg_buf.push_back(bdef_pkg::CH_DICT);
		repeat (DEPTH_LIMIT + 1) msg_buf.push_back(bdef_pkg::CH_END);
		send_buffer();
	endtask

	task automatic test_size_limits();
		send_text("d32768:ab");
		send_text("d32769:abe");
		send_text("d999999e");
	endtask

	task automatic build_random_message();
		int lvl;
		int pick;
		int n;
		int idx;
		msg_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, 5);
			push_decimal(n);
			msg_buf.push_back(bdef_pkg::CH_COLON);
			repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
		end
		msg_buf.push_back($urandom_range(0, 1) ? bdef_pkg::CH_DICT : bdef_pkg::CH_LIST);
		lvl = 1;
		while (lvl > 0) begin
			pick = $urandom_range(0, 9);
			if (msg_buf.size() > 48 || pick < 3) begin
				msg_buf.push_back(bdef_pkg::CH_END);
				lvl--;
			end else if (pick < 5 && lvl < 5) begin
				msg_buf.push_back($urandom_range(0, 1) ? bdef_pkg::CH_DICT : bdef_pkg::CH_LIST);
				lvl++;
			end else if (pick < 8) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
				push_decimal(n);
				msg_buf.push_back(bdef_pkg::CH_COLON);
				repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				msg_buf.push_back(bdef_pkg::CH_INT);
				if ($urandom_range(0, 1))
					msg_buf.push_back("-");
				push_decimal($urandom_range(0, 99999));
				msg_buf.push_back(bdef_pkg::CH_END);
			end
		end
		if ($urandom_range(0, 2) != 0)
			repeat ($urandom_range(1, 6)) msg_buf.push_back(8'($urandom_range(0, 255)));

		// Break about a third of the messages
		pick = $urandom_range(0, 99);
		if (pick >= 70 && pick < 76) begin
			idx = $urandom_range(1, msg_buf.size());
			while (msg_buf.size() > idx) void'(msg_buf.pop_back());
		end else if (pick >= 76 && pick < 84) begin
			idx = $urandom_range(0, msg_buf.size() - 1);
			msg_buf[idx] = 8'($urandom_range(0, 255));
		end else if (pick >= 84 && pick < 88) begin
			msg_buf.push_front(bdef_pkg::CH_END);
		end else if (pick >= 88 && pick < 93) begin
			n = $urandom_range(DEPTH_LIMIT - 2, DEPTH_LIMIT + 1);
			repeat (n) begin
				msg_buf.push_front(bdef_pkg::CH_DICT);
				msg_buf.push_back(bdef_pkg::CH_END);
			end
		end else if (pick >= 93) begin
			msg_buf.delete();
			repeat ($urandom_range(1, 12)) msg_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_messages();
		int sent;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			build_random_message();
			sent += msg_buf.size();
			send_buffer();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wellformed();
		test_malformed();
		test_nest_limit();
		test_size_limits();
		test_random_messages();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_verdicts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
src/bdef_pkg.sv
src/bdef_in_reg.sv
src/bdef_scan.sv
src/bencode_dict_end_finder_top.sv
verif/tb_bencode_dict_end_finder_top.sv
